/* src/lpds_pkg.sv */
// lpds_pkg: shared types and codes for the length-prefixed dictionary splitter
// request and result payloads, command and status codes, parse phase encoding
// no dependencies
`default_nettype none

package lpds_pkg;

	localparam int unsigned PosW      = 31;
	localparam int unsigned GenW      = 32;
	localparam int unsigned PrefixW   = 32;
	localparam int unsigned PrefixLen = 4;
	localparam int unsigned PaddrW    = 3;
	localparam int unsigned PdataW    = 32;

	typedef logic [PosW-1:0] pos_t;

	// request commands
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_BYTE  = 1'b1;

	// register indexes, taken from paddr[2]
	localparam logic REG_PAGE_LEN    = 1'b0;
	localparam logic REG_VALUE_COUNT = 1'b1;

	typedef enum logic [2:0] {
		ST_RUNNING  = 3'd0,
		ST_DONE     = 3'd1,
		ST_TRUNC    = 3'd2,
		ST_OVERRUN  = 3'd3,
		ST_MISMATCH = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_PREFIX = 3'b010,
		PH_VALUE  = 3'b100
	} phase_t;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		logic            entry_valid;
		pos_t            entry_offset;
		pos_t            entry_length;
		status_t         parse_status;
		logic [GenW-1:0] generation;
	} out_t;

	typedef struct packed {
		pos_t page_len;
		pos_t value_count;
	} cfg_t;

endpackage

`default_nettype wire

/* src/lpds_core.sv */
// lpds_core: parse state and per-byte update of the dictionary splitter
// one request handled per cycle when go is high, result is combinational
// depends on lpds_pkg
`default_nettype none

module lpds_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire lpds_pkg::in_t item,
	input  wire lpds_pkg::cfg_t cfg,
	output logic               res_valid,
	output lpds_pkg::out_t     res
);
	import lpds_pkg::*;

	phase_t              phase_q, phase_d;
	logic [PrefixW-1:0]  accum_q, accum_d;
	logic [1:0]          seen_q, seen_d;
	pos_t                left_q, left_d;
	pos_t                pos_q, pos_d;
	pos_t                start_q, start_d;
	pos_t                ent_q, ent_d;
	logic [GenW-1:0]     gen_q, gen_d;

	logic               chk, fin, ovr;
	pos_t               fin_len;
	pos_t               diff;
	logic [PrefixW-1:0] acc_new;
	status_t            st;

	// entry boundary check
	function automatic status_t boundary(input pos_t ent, input pos_t pos, input cfg_t c);
		status_t s;
		pos_t    rem;
		rem = c.page_len - pos;
		if (ent >= c.value_count) begin
			s = (pos == c.page_len) ? ST_DONE : ST_MISMATCH;
		end else if (pos > c.page_len || rem < pos_t'(PrefixLen)) begin
			s = ST_TRUNC;
		end else begin
			s = ST_RUNNING;
		end
		return s;
	endfunction

	always_comb begin
		phase_d = phase_q;
		accum_d = accum_q;
		seen_d  = seen_q;
		left_d  = left_q;
		pos_d   = pos_q;
		start_d = start_q;
		ent_d   = ent_q;
		gen_d   = gen_q;
		chk     = 1'b0;
		fin     = 1'b0;
		ovr     = 1'b0;
		fin_len = '0;
		st      = ST_RUNNING;
		diff    = '0;
		acc_new = accum_q | ({{(PrefixW-8){1'b0}}, item.data_byte} << {seen_q, 3'b000});

		if (item.command == CMD_START) begin
			pos_d   = '0;
			ent_d   = '0;
			start_d = '0;
			left_d  = '0;
			accum_d = '0;
			seen_d  = '0;
			chk     = 1'b1;
		end else begin
			unique case (phase_q)
				PH_PREFIX: begin
					pos_d   = pos_q + pos_t'(1);
					accum_d = acc_new;
					diff    = cfg.page_len - pos_d;
					if (seen_q != 2'd3) begin
						seen_d = seen_q + 2'd1;
					end else begin
						seen_d  = '0;
						start_d = pos_d;
						if (pos_d > cfg.page_len || acc_new > {1'b0, diff}) begin
							phase_d = PH_IDLE;
							ovr     = 1'b1;
						end else if (acc_new == '0) begin
							fin = 1'b1;
						end else begin
							left_d  = acc_new[PosW-1:0];
							phase_d = PH_VALUE;
						end
					end
				end
				PH_VALUE: begin
					pos_d  = pos_q + pos_t'(1);
					left_d = left_q - pos_t'(1);
					if (left_d == '0) begin
						phase_d = PH_IDLE;
						fin     = 1'b1;
						fin_len = accum_q[PosW-1:0];
					end
				end
				PH_IDLE: begin
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end

		if (fin) begin
			ent_d = ent_q + pos_t'(1);
			chk   = 1'b1;
		end

		if (chk) begin
			st = boundary(ent_d, pos_d, cfg);
			if (st == ST_DONE) begin
				gen_d = gen_q + GenW'(1);
			end
			if (st == ST_RUNNING) begin
				phase_d = PH_PREFIX;
				accum_d = '0;
				seen_d  = '0;
			end else begin
				phase_d = PH_IDLE;
			end
		end

		res_valid          = fin || ovr || (chk && st != ST_RUNNING);
		res.entry_valid    = fin;
		res.entry_offset   = fin ? start_d : '0;
		res.entry_length   = fin ? fin_len : '0;
		res.parse_status   = ovr ? ST_OVERRUN : st;
		res.generation     = gen_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			accum_q <= '0;
			seen_q  <= '0;
			left_q  <= '0;
			pos_q   <= '0;
			start_q <= '0;
			ent_q   <= '0;
			gen_q   <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			accum_q <= accum_d;
			seen_q  <= seen_d;
			left_q  <= left_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			ent_q   <= ent_d;
			gen_q   <= gen_d;
		end
	end

endmodule

`default_nettype wire

/* src/length_prefixed_dictionary_splitter.sv */
// length_prefixed_dictionary_splitter: top level of the dictionary splitter
// request register, parse core, result register and apb register file
// depends on lpds_pkg and lpds_core
//
// channel  direction  handshake                 payload
// -------  ---------  ------------------------  --------------------------------
// in       request    in_valid / in_ready       in_item  (lpds_pkg::in_t)
// out      result     out_valid / out_ready     out_item (lpds_pkg::out_t)
// apb      config     psel penable pwrite       paddr pwdata prdata, pready tied
//
// one request per cycle while results are taken; a request waits in the input
// register until the result slot frees, and its result, if any, is registered
// into the output register as it moves on; the parse core updates its counters
// once per request; reset clears all parse state, the generation count, the
// config registers and both valid flags; a stalled result holds the output
// register; the input drains into it in the same cycle the result is taken
`default_nettype none

module length_prefixed_dictionary_splitter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire lpds_pkg::in_t                 in_item,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output lpds_pkg::out_t                     out_item,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lpds_pkg::PaddrW-1:0]   paddr,
	input  wire logic [lpds_pkg::PdataW-1:0]   pwdata,
	output logic [lpds_pkg::PdataW-1:0]        prdata,
	output logic                               pready
);
	import lpds_pkg::*;

	// request stage
	in_t  item_s1;
	logic valid_s1;

	// result stage
	out_t res_s2;
	logic valid_s2;

	// config registers
	pos_t page_len_q;
	pos_t value_count_q;
	cfg_t cfg;

	logic go;
	logic core_res_valid;
	out_t core_res;
	logic wr_en;

	// request in stage one moves on when the result slot is free or draining
	assign go       = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	assign cfg.page_len    = page_len_q;
	assign cfg.value_count = value_count_q;

	lpds_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (core_res_valid),
		.res       (core_res)
	);

	// result register; requests that give no result just clear the slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go) begin
			valid_s2 <= core_res_valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && core_res_valid) begin
			res_s2 <= core_res;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = res_s2;

	// apb register file, no wait states
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_len_q    <= '0;
			value_count_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_PAGE_LEN:    page_len_q    <= pwdata[PosW-1:0];
				REG_VALUE_COUNT: value_count_q <= pwdata[PosW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_PAGE_LEN:    prdata = {{(PdataW-PosW){1'b0}}, page_len_q};
			REG_VALUE_COUNT: prdata = {{(PdataW-PosW){1'b0}}, value_count_q};
			default:         prdata = '0;
		endcase
	end

`ifndef SYNTH
	// a reported entry never carries an overrun
	a_entry_not_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.entry_valid) |-> (out_item.parse_status != ST_OVERRUN))
		else $error("entry reported with overrun status");

	// a result while still running is always an entry
	a_running_is_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.parse_status == ST_RUNNING) |-> out_item.entry_valid)
		else $error("running status without an entry");

	// a request with no result leaves the result slot empty
	a_no_result_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(go && !core_res_valid) |=> !out_valid)
		else $error("result slot filled by a request without a result");
`endif

endmodule

`default_nettype wire

/* tb/tb_length_prefixed_dictionary_splitter.sv */
// tb_length_prefixed_dictionary_splitter: self-checking bench for the dictionary splitter
// drives start and byte requests, programs page length and value_count over apb,
// predicts every entry and status result and compares it; depends on lpds_pkg and the dut
module tb_length_prefixed_dictionary_splitter;
	timeunit 1ns;
	timeprecision 1ps;

	import lpds_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 400_000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned REQUEST_GOAL  = 650;
	localparam int unsigned QUIET_FROM    = 560;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// request side
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_item = '0;

	// result side
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_item;

	// register port
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [PaddrW-1:0] paddr = '0;
	logic [PdataW-1:0] pwdata = '0;
	logic [PdataW-1:0] prdata;
	logic              pready;

	length_prefixed_dictionary_splitter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #5 clk = ~clk;

	// requests waiting to be driven, and results the parse should produce, oldest first
	in_t  pending_requests[$];
	out_t expected_reports[$];
	int unsigned requests_queued = 0;
	int unsigned requests_taken = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	// idling is allowed only while bursty is set; cleared for the tail of the run
	bit bursty = 1'b0;
	int gap_left = 0;
	int stall_left = 0;

	// ------------------------------------------------------------------
	// parse predictor: its own copy of the registers and the parse state
	// ------------------------------------------------------------------
	pos_t        cfg_page_len = '0;
	pos_t        cfg_value_count = '0;
	phase_t      parse_phase = PH_IDLE;
	logic [31:0] prefix_accum = '0;
	logic [1:0]  prefix_seen = '0;
	pos_t        value_left = '0;
	pos_t        byte_pos = '0;
	pos_t        value_start = '0;
	pos_t        entries_done = '0;
	logic [31:0] load_count = '0;

	function automatic void report(logic valid, pos_t off, pos_t len, status_t st);
		out_t r;
		r.entry_valid  = valid;
		r.entry_offset = off;
		r.entry_length = len;
		r.parse_status = st;
		r.generation   = load_count;
		expected_reports.push_back(r);
	endfunction

	// runs at start and after each entry: decides done, mismatch, truncation or next prefix
	function automatic status_t check_boundary();
		if (entries_done >= cfg_value_count) begin
			parse_phase = PH_IDLE;
			if (byte_pos == cfg_page_len) begin
				load_count = load_count + 1;
				return ST_DONE;
			end
			return ST_MISMATCH;
		end
		if (byte_pos > cfg_page_len || cfg_page_len - byte_pos < PrefixLen) begin
			parse_phase = PH_IDLE;
			return ST_TRUNC;
		end
		parse_phase = PH_PREFIX;
		prefix_accum = '0;
		prefix_seen = '0;
		return ST_RUNNING;
	endfunction

	function automatic void close_entry(pos_t len);
		status_t st;
		entries_done = entries_done + 1'b1;
		st = check_boundary();
		report(1'b1, value_start, len, st);
	endfunction

	function automatic void advance_parse(in_t req);
		status_t st;
		if (req.command == CMD_START) begin
			// a start also aborts whatever parse is running
			byte_pos = '0;
			entries_done = '0;
			value_start = '0;
			value_left = '0;
			prefix_accum = '0;
			prefix_seen = '0;
			st = check_boundary();
			if (st != ST_RUNNING)
				report(1'b0, '0, '0, st);
		end else if (parse_phase == PH_PREFIX) begin
			// little-endian length prefix, one byte per request
			prefix_accum = prefix_accum | (32'(req.data_byte) << (8 * prefix_seen));
			byte_pos = byte_pos + 1'b1;
			if (prefix_seen < 2'd3) begin
				prefix_seen = prefix_seen + 1'b1;
			end else begin
				prefix_seen = '0;
				value_start = byte_pos;
				if (byte_pos > cfg_page_len ||
				    prefix_accum > 32'(cfg_page_len - byte_pos)) begin
					// value would run past the page
					parse_phase = PH_IDLE;
					report(1'b0, '0, '0, ST_OVERRUN);
				end else if (prefix_accum == 0) begin
					// empty value closes the entry on the last prefix byte
					close_entry('0);
				end else begin
					value_left = prefix_accum[PosW-1:0];
					parse_phase = PH_VALUE;
				end
			end
		end else if (parse_phase == PH_VALUE) begin
			byte_pos = byte_pos + 1'b1;
			value_left = value_left - 1'b1;
			if (value_left == 0) begin
				parse_phase = PH_IDLE;
				close_entry(prefix_accum[PosW-1:0]);
			end
		end
		// bytes while idle are dropped without a result
	endfunction

	// ------------------------------------------------------------------
	// request driver: presents queued requests, predicts each one as it is taken
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				advance_parse(in_item);
				requests_taken = requests_taken + 1;
			end
			// valid only changes once the current request is gone
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left = gap_left - 1;
				end else if (bursty && $urandom_range(0, 9) == 0) begin
					in_valid <= 1'b0;
					gap_left = $urandom_range(1, 13) - 1;
				end else if (pending_requests.size() > 0) begin
					in_item <= pending_requests.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result monitor: checks each taken result against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					$error("unexpected result: entry_valid %0d offset %0d length %0d status %0d",
						out_item.entry_valid, out_item.entry_offset,
						out_item.entry_length, out_item.parse_status);
					mismatches = mismatches + 1;
				end else begin
					want = expected_reports.pop_front();
					if (out_item.entry_valid !== want.entry_valid) begin
						$error("entry_valid: expected %0d, actual %0d",
							want.entry_valid, out_item.entry_valid);
						mismatches = mismatches + 1;
					end
					if (out_item.entry_offset !== want.entry_offset) begin
						$error("entry_offset: expected %0d, actual %0d",
							want.entry_offset, out_item.entry_offset);
						mismatches = mismatches + 1;
					end
					if (out_item.entry_length !== want.entry_length) begin
						$error("entry_length: expected %0d, actual %0d",
							want.entry_length, out_item.entry_length);
						mismatches = mismatches + 1;
					end
					if (out_item.parse_status !== want.parse_status) begin
						$error("parse_status: expected %0d, actual %0d",
							want.parse_status, out_item.parse_status);
						mismatches = mismatches + 1;
					end
					if (out_item.generation !== want.generation) begin
						$error("generation: expected %0d, actual %0d",
							want.generation, out_item.generation);
						mismatches = mismatches + 1;
					end
				end
			end
			// receiver back-pressure in random bursts
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left = stall_left - 1;
			end else if (bursty && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(1, 13) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_req(logic cmd, logic [7:0] b);
		in_t r;
		r.command = cmd;
		r.data_byte = b;
		pending_requests.push_back(r);
		requests_queued = requests_queued + 1;
	endtask

	task automatic push_prefix(logic [31:0] len);
		for (int i = 0; i < 4; i++)
			push_req(CMD_BYTE, len[8*i +: 8]);
	endtask

	// everything taken, every result back, then room for a request still in flight
	task automatic wait_drained();
		while (requests_taken != requests_queued || expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// drain, then push 0xff bytes until the parse has ended so registers change while idle;
	// 0xff prefix bytes always overrun, value bytes just run the entry out
	task automatic settle_parse();
		wait_drained();
		while (parse_phase != PH_IDLE) begin
			push_req(CMD_BYTE, 8'hFF);
			wait_drained();
		end
	endtask

	// apb write: setup cycle, access cycle, register takes the value at the end of access
	task automatic write_register(logic idx, logic [PdataW-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_PAGE_LEN)
			cfg_page_len = value[PosW-1:0];
		else
			cfg_value_count = value[PosW-1:0];
	endtask

	// one register setting and a few pages against it; about half the settings are well formed,
	// the rest are bent so every ending status shows up
	task automatic random_phase(bit quiet);
		int unsigned lens[$];
		logic [7:0]  page[$];
		int unsigned nent, total, mode, cut;
		logic [31:0] dl, vc;
		nent = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4);
		total = 0;
		for (int i = 0; i < nent; i++) begin
			lens.push_back(($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
			                                           : $urandom_range(0, 6));
			total = total + PrefixLen + lens[i];
		end
		dl = total;
		vc = nent;
		mode = $urandom_range(0, 11);
		case (mode)
			6: dl = total + $urandom_range(1, 6);                     // page longer than entries
			7: if (total > 0) dl = total - $urandom_range(1, total);  // page cut short
			8: vc = nent + $urandom_range(1, 2);                      // too many entries asked
			9: if (nent > 0) vc = nent - 1;                           // too few entries asked
			default: ;
		endcase
		settle_parse();
		write_register(REG_PAGE_LEN, dl);
		write_register(REG_VALUE_COUNT, vc);
		bursty = !quiet && $urandom_range(0, 3) != 0;
		repeat ($urandom_range(1, 3)) begin
			page.delete();
			foreach (lens[i]) begin
				for (int k = 0; k < 4; k++)
					page.push_back(8'(lens[i] >> (8 * k)));
				repeat (lens[i]) page.push_back(8'($urandom_range(0, 255)));
			end
			// a corrupted byte, often inside a prefix where it misaligns the rest of the page
			if (mode == 10 && page.size() > 0)
				page[$urandom_range(0, page.size() - 1)] = 8'($urandom_range(0, 255));
			// a stray byte ahead of the start: dropped, or fed into an aborted parse
			if ($urandom_range(0, 5) == 0)
				push_req(CMD_BYTE, 8'($urandom_range(0, 255)));
			push_req(CMD_START, 8'($urandom_range(0, 255)));
			cut = page.size();
			if (mode == 11 && page.size() > 0)
				cut = $urandom_range(0, page.size() - 1);  // next start aborts this one
			for (int i = 0; i < cut; i++)
				push_req(CMD_BYTE, page[i]);
		end
	endtask

	// ------------------------------------------------------------------
	// run watchdog
	// ------------------------------------------------------------------
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles = cycles + 1;
		end
		$display("length_prefixed_dictionary_splitter regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// registers at reset: a byte before any start is dropped, then a start on an
		// empty page with no entries completes at once and bumps the generation
		push_req(CMD_BYTE, 8'hA5);
		push_req(CMD_START, 8'h00);

		// largest page and entry count; bit 31 of the written word is not stored
		settle_parse();
		write_register(REG_PAGE_LEN, 32'hFFFF_FFFF);
		write_register(REG_VALUE_COUNT, 32'h7FFF_FFFF);
		push_req(CMD_START, 8'h00);
		push_prefix(32'h7FFF_FFFB);  // exactly the bytes left: accepted
		push_req(CMD_BYTE, 8'h00);
		push_req(CMD_START, 8'hFF);  // abort mid-value and restart
		push_prefix(32'h7FFF_FFFC);  // one byte too many: overrun
		push_req(CMD_BYTE, 8'h5A);   // dropped after the error

		// empty value ends the entry on the last prefix byte; one byte left over
		// means the entry count is reached with the position short of the page
		settle_parse();
		write_register(REG_PAGE_LEN, 32'd5);
		write_register(REG_VALUE_COUNT, 32'd1);
		push_req(CMD_START, 8'h00);
		push_prefix(32'h0000_0000);

		// empty entry, then fewer than four bytes left for the next prefix
		settle_parse();
		write_register(REG_PAGE_LEN, 32'd6);
		write_register(REG_VALUE_COUNT, 32'd2);
		push_req(CMD_START, 8'h00);
		push_prefix(32'h0000_0000);

		// random pages; the tail runs with no idling on either side
		while (requests_queued < REQUEST_GOAL)
			random_phase(requests_queued >= QUIET_FROM);

		wait_drained();
		if (mismatches == 0)
			$display("length_prefixed_dictionary_splitter regression: pass");
		else
			$display("length_prefixed_dictionary_splitter regression: fail");
		$finish;
	end

endmodule
